// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low synchronous reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low synchronous reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mvh_pkg.sv =====
// Shared constants and types of the material volume histogram unit.
package mvh_pkg;

    localparam int NUM_MATERIALS = 256;
    localparam int COUNT_BITS    = 64;
    localparam int ADDR_W        = $clog2(NUM_MATERIALS);
    localparam int ID_W          = 8;
    localparam int EXT_W         = 34;
    localparam int MAG_W         = EXT_W - 1;
    localparam int PROD_W        = 2 * MAG_W;
    localparam int HALF_W        = COUNT_BITS / 2;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic load;
        logic mul_xy;
        logic mul_lo;
        logic mul_hi;
        logic fold;
        logic add;
        logic report;
    } t_dp_cmd;

endpackage

// ===== hw/rtl/mvh_ctrl.sv =====
// Sequencing controller of the material volume histogram unit.
module mvh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_command,
    output logic           busy,
    output logic           o_result_valid,
    output mvh_pkg::t_dp_cmd o_cmd
);
    import mvh_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_MUL_XY = 7'b0000100,
        S_MUL_LO = 7'b0001000,
        S_MUL_HI = 7'b0010000,
        S_FOLD   = 7'b0100000,
        S_ADD    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;
    logic   accept;

    assign busy           = (r_state != S_IDLE);
    assign accept         = start && !busy;
    assign o_result_valid = r_strobe;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_command == CMD_READ) ? S_READ : S_MUL_XY;
                end
            end
            S_READ: begin
                o_cmd.report = 1'b1;
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
            end
            S_MUL_XY: begin
                o_cmd.mul_xy = 1'b1;
                n_state      = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

endmodule

// ===== hw/rtl/mvh_datapath.sv =====
// Datapath of the material volume histogram unit: bin store, multiplier and adder.
module mvh_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mvh_pkg::t_dp_cmd                i_cmd,
    input  logic [mvh_pkg::ID_W-1:0]        i_material_id,
    input  logic signed [mvh_pkg::EXT_W-1:0] i_extent_x,
    input  logic signed [mvh_pkg::EXT_W-1:0] i_extent_y,
    input  logic signed [mvh_pkg::EXT_W-1:0] i_extent_z,
    output logic [mvh_pkg::ID_W-1:0]        o_bin_id,
    output logic [mvh_pkg::COUNT_BITS-1:0]  o_bin_count,
    output logic                            o_bin_overflow
);
    import mvh_pkg::*;

    logic [COUNT_BITS:0]   r_mem [NUM_MATERIALS];
    logic [NUM_MATERIALS-1:0] r_valid;
    logic [COUNT_BITS:0]   r_rd_data;
    logic                  r_rd_valid;

    logic [ID_W-1:0]       r_id;
    logic [MAG_W-1:0]      r_w, r_h, r_d;
    logic [PROD_W-1:0]     r_p1;
    logic [MAG_W+HALF_W-1:0] r_pp_lo, r_pp_hi;
    logic [PROD_W-1:0]     r_t;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_flag;

    logic [ADDR_W-1:0]     in_addr, addr;
    logic                  id_ok;
    logic [MAG_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     product;
    logic [COUNT_BITS-1:0] cur_count, vol;
    logic                  cur_flag, ov_mul, new_flag;
    logic [COUNT_BITS:0]   sum;

    function automatic logic [MAG_W-1:0] clamp(input logic [EXT_W-1:0] ext);
        return ext[EXT_W-1] ? '0 : ext[MAG_W-1:0];
    endfunction

    assign in_addr = ADDR_W'(i_material_id);
    assign addr    = ADDR_W'(r_id);
    assign id_ok   = (32'(r_id) < 32'(NUM_MATERIALS));

    always_comb begin
        if (i_cmd.mul_xy) begin
            mul_a = r_w;
            mul_b = r_h;
        end else if (i_cmd.mul_lo) begin
            mul_a = MAG_W'(r_p1[HALF_W-1:0]);
            mul_b = r_d;
        end else begin
            mul_a = MAG_W'(r_p1[COUNT_BITS-1:HALF_W]);
            mul_b = r_d;
        end
    end

    assign product   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign cur_count = r_rd_valid ? r_rd_data[COUNT_BITS-1:0] : '0;
    assign cur_flag  = r_rd_valid ? r_rd_data[COUNT_BITS] : 1'b0;
    assign vol       = {r_t[HALF_W-1:0], r_pp_lo[HALF_W-1:0]};
    assign ov_mul    = (|r_p1[PROD_W-1:COUNT_BITS]) || (|r_t[PROD_W-1:HALF_W]);
    assign sum       = {1'b0, cur_count} + {1'b0, vol};
    assign new_flag  = cur_flag || ov_mul || sum[COUNT_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data <= r_mem[in_addr];
            r_id      <= i_material_id;
            r_w       <= clamp(i_extent_x);
            r_h       <= clamp(i_extent_y);
            r_d       <= clamp(i_extent_z);
        end
        if (i_cmd.add && id_ok) begin
            r_mem[addr] <= {new_flag, sum[COUNT_BITS-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_valid <= r_valid[in_addr];
            end
            if (i_cmd.add && id_ok) begin
                r_valid[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_xy) begin
            r_p1 <= product;
        end
        if (i_cmd.mul_lo) begin
            r_pp_lo <= product[MAG_W+HALF_W-1:0];
        end
        if (i_cmd.mul_hi) begin
            r_pp_hi <= product[MAG_W+HALF_W-1:0];
        end
        if (i_cmd.fold) begin
            r_t <= PROD_W'(r_pp_lo[MAG_W+HALF_W-1:HALF_W]) + PROD_W'(r_pp_hi);
        end
        if (i_cmd.add) begin
            r_count <= id_ok ? sum[COUNT_BITS-1:0] : '0;
            r_flag  <= id_ok ? new_flag : 1'b0;
        end else if (i_cmd.report) begin
            r_count <= id_ok ? cur_count : '0;
            r_flag  <= id_ok ? cur_flag : 1'b0;
        end
    end

    assign o_bin_id       = r_id;
    assign o_bin_count    = r_count;
    assign o_bin_overflow = r_flag;

endmodule

// ===== hw/rtl/material_volume_histogram_unit.sv =====
// Top level of the material volume histogram unit.
//
// A command is taken at a rising edge where start is high and busy is low.
// An accumulate command clamps the three signed extents at zero, multiplies
// them and adds the volume to the addressed bin's 64-bit count, setting the
// bin's sticky overflow flag when a multiply or the add overflows.
// A read command reports the bin unchanged.
// Each command gives one result, shown for one cycle with o_result_valid high;
// the receiver takes it in that cycle and cannot hold it off.
// A read command passes through S_READ before its result is shown; an
// accumulate passes through S_MUL_XY, S_MUL_LO, S_MUL_HI, S_FOLD and S_ADD,
// because one 33 by 33 bit multiplier is shared over three passes, followed
// by a fold of the partial products and the add. busy is low in the cycle
// the result is shown, so a new command may be transferred then.
// The bin store is a 256-entry memory with one valid bit per entry; reset
// clears the valid bits at once, so every bin reads as zero after reset and
// the unit accepts commands as soon as reset is released.
`include "assert_macros.svh"

module material_volume_histogram_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_command,
    input  logic [mvh_pkg::ID_W-1:0]        i_material_id,
    input  logic signed [mvh_pkg::EXT_W-1:0] i_extent_x,
    input  logic signed [mvh_pkg::EXT_W-1:0] i_extent_y,
    input  logic signed [mvh_pkg::EXT_W-1:0] i_extent_z,
    output logic                            o_result_valid,
    output logic [mvh_pkg::ID_W-1:0]        o_bin_id,
    output logic [mvh_pkg::COUNT_BITS-1:0]  o_bin_count,
    output logic                            o_bin_overflow
);
    import mvh_pkg::*;

    t_dp_cmd dp_cmd;

    mvh_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_command      (i_command),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (dp_cmd)
    );

    mvh_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_material_id  (i_material_id),
        .i_extent_x     (i_extent_x),
        .i_extent_y     (i_extent_y),
        .i_extent_z     (i_extent_z),
        .o_bin_id       (o_bin_id),
        .o_bin_count    (o_bin_count),
        .o_bin_overflow (o_bin_overflow)
    );

    `ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_result_valid, !busy, "result shown while busy")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after transfer")
    `ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_result_valid, !o_result_valid, "result repeated")
    `ASSERT_NEXT(a_read_latency, i_clk, i_rst_n, start && !busy && (i_command == CMD_READ), ##1 o_result_valid, "read result late")

endmodule
